// ===== rtl/core/effect_volume_pool_macros.svh =====
// Assertion macros used by the effect volume pool checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef EFFECT_VOLUME_POOL_MACROS_SVH
`define EFFECT_VOLUME_POOL_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define EVP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define EVP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/evp_pkg.sv =====
// Package for the effect volume pool: widths, codes, record layout and entry type.
// No dependencies; used by the top level and the checker.
package evp_pkg;

    localparam int POOL_CAPACITY_DEF = 64;
    localparam int CNT_W             = 7;
    localparam int FADE_W            = 17;
    localparam int IN_DATA_W         = 304;
    localparam int OUT_DATA_W        = 216;

    localparam logic [FADE_W-1:0] FADE_RESET = 17'd6554;
    localparam logic [FADE_W-1:0] Q16_ONE    = 17'h10000;
    localparam logic [31:0]       MIN_LIFE   = 32'd66;

    // Item kinds carried in the slave-side tuser.
    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Bit positions of selected result fields in the master-side tdata.
    localparam int OUT_PROG_LSB = 176;
    localparam int OUT_LIVE_LSB = 209;

    // One pool entry as it is kept in the entry memory.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] rise;
        logic [31:0] life;
        logic [15:0] density;
        logic [31:0] growth;
        logic [30:0] radius;
        logic [30:0] height;
        logic [31:0] age;
        logic [15:0] seed;
        logic [15:0] scale;
    } evp_entry_t;

endpackage

// ===== rtl/core/evp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module evp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/effect_volume_pool.sv =====
// Effect volume pool. An emit writes the new entry, then makes one record pass. A tick
// ages each visited entry, then makes one record per survivor; each record runs a 16-step
// shift-subtract division for progress and, unless progress has reached the fade-in
// fraction, a second one for swelling. Clear and refused items give one empty record. One
// item at a time; the next is taken as soon as the last record sits in the output register.
// Reset (rst_n, async, low) empties the pool and loads the fade register; the entry memory is not cleared.
module effect_volume_pool #(
    parameter int POOL_CAPACITY = evp_pkg::POOL_CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input beats. s_tdata, from bit 0 up: pos_x, pos_y, pos_z, rise_rate, time_value,
    // base_density, growth_rate, base_radius, base_height, size_scale, seed_value, 2 pad.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [evp_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                       s_tuser,   // kind
    // Result beats. m_tdata, from bit 0 up: out_x, out_y, out_z, density_now,
    // extent_horizontal, extent_vertical, progress, seed_out, live_count.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [evp_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [0:0]                       m_tuser,   // valid_res
    output logic                             m_tlast,
    // Fade-in fraction register write.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [evp_pkg::FADE_W-1:0]       cfg_data
);

    import evp_pkg::*;

    localparam int AW = (POOL_CAPACITY > 1) ? $clog2(POOL_CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(POOL_CAPACITY);
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int ENTRY_W = $bits(evp_entry_t);

    // The sequencer. Tick states age the pool in place; record states build one
    // result record from one memory read.
    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_EMPTY  = 16'h0002,
        ST_T_RD   = 16'h0004,
        ST_T_UP1  = 16'h0008,
        ST_T_UP2  = 16'h0010,
        ST_T_UP3  = 16'h0020,
        ST_R_RD   = 16'h0040,
        ST_R_EX1  = 16'h0080,
        ST_R_EX2  = 16'h0100,
        ST_R_EX3  = 16'h0200,
        ST_R_DIV1 = 16'h0400,
        ST_R_SW   = 16'h0800,
        ST_R_DIV2 = 16'h1000,
        ST_R_MUL1 = 16'h2000,
        ST_R_MUL2 = 16'h4000,
        ST_R_OUT  = 16'h8000
    } state_t;

    // Saturates a scaled extent magnitude (already times scale, Q8.8) to signed 32 bits.
    function automatic logic [31:0] ext_sat(input logic [64:0] prod, input logic neg);
        logic [56:0] m;
        begin
            m = prod[64:8];
            if (!neg)
            begin
                ext_sat = (m > 57'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
            end
            else
            begin
                ext_sat = (m > 57'h80000000) ? 32'h80000000 : (32'd0 - m[31:0]);
            end
        end
    endfunction

    // Control state.
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [FADE_W-1:0]    fade_reg, fade_next;
    logic [CNT_W-1:0]     src_reg, src_next;
    logic [CNT_W-1:0]     dst_reg, dst_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 mvalid_reg, mvalid_next;

    // Datapath registers.
    logic [31:0]            tv_reg, tv_next;
    logic [47:0]            rm_reg, rm_next;
    logic [31:0]            age_reg, age_next;
    logic                   expired_reg, expired_next;
    logic [63:0]            pa_reg, pa_next;
    logic [63:0]            pb_reg, pb_next;
    logic [63:0]            gmul_reg, gmul_next;
    logic [48:0]            absh_reg, absh_next;
    logic [48:0]            absv_reg, absv_next;
    logic                   negh_reg, negh_next;
    logic                   negv_reg, negv_next;
    logic [64:0]            mh_reg, mh_next;
    logic [64:0]            mv_reg, mv_next;
    logic [31:0]            rem_reg, rem_next;
    logic [31:0]            dvs_reg, dvs_next;
    logic [15:0]            quo_reg, quo_next;
    logic [FADE_W-1:0]      t_reg, t_next;
    logic [FADE_W-1:0]      sw_reg, sw_next;
    logic [32:0]            p1_reg, p1_next;
    logic [49:0]            p2_reg, p2_next;
    logic [OUT_DATA_W-1:0]  mdata_reg, mdata_next;
    logic                   muser_reg, muser_next;
    logic                   mlast_reg, mlast_next;

    // Entry memory ports.
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    evp_entry_t         ent, new_ent, upd_ent;

    // Combinational helpers.
    logic              in_accept, out_free, rec_last;
    logic [31:0]       in_time;
    logic [FADE_W-1:0] fade_eff;
    logic [31:0]       rise_mag, growth_mag;
    logic [32:0]       age_sum;
    logic [31:0]       age_sat;
    logic [63:0]       dsum;
    logic [41:0]       z_wide;
    logic [31:0]       z_sat;
    logic [49:0]       grown, sum_h, sum_v;
    logic [32:0]       rem_sh;
    logic              div_ge;
    logic [31:0]       rem_new;
    logic [15:0]       quo_new;

    evp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ent = ram_rdata;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;
    assign m_tlast   = mlast_reg;

    // The output register can take a new record when empty or draining this cycle.
    assign out_free = !mvalid_reg || m_tready;
    assign rec_last = (src_reg == count_reg - 1'b1);
    assign fade_eff = (fade_reg == '0) ? FADE_W'(1) : fade_reg;
    assign in_time  = s_tdata[159:128];

    // A new entry as written by an emit: life raised to the minimum, age zero.
    always_comb
    begin
        new_ent.pos_x   = s_tdata[31:0];
        new_ent.pos_y   = s_tdata[63:32];
        new_ent.pos_z   = s_tdata[95:64];
        new_ent.rise    = s_tdata[127:96];
        new_ent.life    = (in_time < MIN_LIFE) ? MIN_LIFE : in_time;
        new_ent.density = s_tdata[175:160];
        new_ent.growth  = s_tdata[207:176];
        new_ent.radius  = s_tdata[238:208];
        new_ent.height  = s_tdata[269:239];
        new_ent.scale   = s_tdata[285:270];
        new_ent.seed    = s_tdata[301:286];
        new_ent.age     = '0;
    end

    // Aging arithmetic. The rise delta is |rise| * scale * dt, split over the integer
    // and fraction halves of dt so that no product is wider than 48 by 16 bits.
    assign rise_mag = ent.rise[31] ? (32'd0 - ent.rise) : ent.rise;
    assign age_sum  = {1'b0, ent.age} + {1'b0, tv_reg};
    assign age_sat  = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
    assign dsum     = pa_reg + (pb_reg >> 16);
    assign z_wide   = ent.rise[31] ? ({{10{ent.pos_z[31]}}, ent.pos_z} - {2'b00, dsum[63:24]})
                                   : ({{10{ent.pos_z[31]}}, ent.pos_z} + {2'b00, dsum[63:24]});
    assign z_sat    = (z_wide[41:31] == '0 || z_wide[41:31] == '1) ? z_wide[31:0]
                    : (z_wide[41] ? 32'h80000000 : 32'h7FFFFFFF);

    always_comb
    begin
        upd_ent       = ent;
        upd_ent.pos_z = z_sat;
        upd_ent.age   = age_reg;
    end

    // Extent arithmetic: base plus or minus (|growth| * age) >> 16, signed, 50 bits.
    assign growth_mag = ent.growth[31] ? (32'd0 - ent.growth) : ent.growth;
    assign grown      = ent.growth[31] ? (50'd0 - {2'b00, gmul_reg[63:16]})
                                       : {2'b00, gmul_reg[63:16]};
    assign sum_h      = {19'd0, ent.radius} + grown;
    assign sum_v      = {19'd0, ent.height} + grown;

    // One restoring division step; the quotient is known to fit in 16 bits.
    assign rem_sh  = {rem_reg, 1'b0};
    assign div_ge  = (rem_sh >= {1'b0, dvs_reg});
    assign rem_new = div_ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
    assign quo_new = {quo_reg[14:0], div_ge};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        fade_next    = cfg_valid ? cfg_data : fade_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        cnt_next     = cnt_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        tv_next      = tv_reg;
        rm_next      = rm_reg;
        age_next     = age_reg;
        expired_next = expired_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        gmul_next    = gmul_reg;
        absh_next    = absh_reg;
        absv_next    = absv_reg;
        negh_next    = negh_reg;
        negv_next    = negv_reg;
        mh_next      = mh_reg;
        mv_next      = mv_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        quo_next     = quo_reg;
        t_next       = t_reg;
        sw_next      = sw_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        mlast_next   = mlast_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = dst_reg[AW-1:0];
        ram_wdata    = upd_ent;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_tuser)
                        KIND_EMIT:
                        begin
                            if (count_reg >= CAP)
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                // Store at the end of the pool, then report it.
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = new_ent;
                                count_next = count_reg + 1'b1;
                                src_next   = count_reg;
                                state_next = ST_R_RD;
                            end
                        end
                        KIND_TICK:
                        begin
                            tv_next    = in_time;
                            src_next   = '0;
                            dst_next   = '0;
                            state_next = (count_reg == '0) ? ST_EMPTY : ST_T_RD;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_EMPTY;
                        end
                        default:
                        begin
                            state_next = ST_EMPTY;
                        end
                    endcase
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {count_reg, 209'd0};
                    muser_next  = 1'b0;
                    mlast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_T_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_T_UP1;
            end

            ST_T_UP1:
            begin
                rm_next      = 48'(rise_mag) * 48'(ent.scale);
                age_next     = age_sat;
                expired_next = (age_sat >= ent.life);
                state_next   = ST_T_UP2;
            end

            ST_T_UP2:
            begin
                pa_next    = 64'(rm_reg) * 64'(tv_reg[31:16]);
                pb_next    = 64'(rm_reg) * 64'(tv_reg[15:0]);
                state_next = ST_T_UP3;
            end

            ST_T_UP3:
            begin
                // Swap-remove: an expired entry is replaced by the last live one, which
                // is then aged into the same slot before the walk moves on.
                if (!expired_reg)
                begin
                    ram_we = 1'b1;
                    if (dst_reg + 1'b1 < count_reg)
                    begin
                        dst_next   = dst_reg + 1'b1;
                        src_next   = dst_reg + 1'b1;
                        state_next = ST_T_RD;
                    end
                    else
                    begin
                        src_next   = '0;
                        state_next = ST_R_RD;
                    end
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (dst_reg < count_reg - 1'b1)
                    begin
                        src_next   = count_reg - 1'b1;
                        state_next = ST_T_RD;
                    end
                    else
                    begin
                        src_next   = '0;
                        state_next = (count_reg == CNT_W'(1)) ? ST_EMPTY : ST_R_RD;
                    end
                end
            end

            ST_R_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_R_EX1;
            end

            ST_R_EX1:
            begin
                gmul_next  = 64'(growth_mag) * 64'(ent.age);
                state_next = ST_R_EX2;
            end

            ST_R_EX2:
            begin
                absh_next  = sum_h[49] ? 49'(50'd0 - sum_h) : sum_h[48:0];
                absv_next  = sum_v[49] ? 49'(50'd0 - sum_v) : sum_v[48:0];
                negh_next  = sum_h[49];
                negv_next  = sum_v[49];
                state_next = ST_R_EX3;
            end

            ST_R_EX3:
            begin
                mh_next    = 65'(absh_reg) * 65'(ent.scale);
                mv_next    = 65'(absv_reg) * 65'(ent.scale);
                // Progress = (age << 16) / life; a live entry has age below life.
                rem_next   = ent.age;
                dvs_next   = ent.life;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_R_DIV1;
            end

            ST_R_DIV1:
            begin
                rem_next = rem_new;
                quo_next = quo_new;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_R_SW;
                end
            end

            ST_R_SW:
            begin
                t_next = {1'b0, quo_reg};
                // Swelling saturates once progress reaches the fade-in fraction.
                if ({1'b0, quo_reg} >= fade_eff)
                begin
                    sw_next    = Q16_ONE;
                    state_next = ST_R_MUL1;
                end
                else
                begin
                    rem_next   = {16'd0, quo_reg};
                    dvs_next   = {15'd0, fade_eff};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_R_DIV2;
                end
            end

            ST_R_DIV2:
            begin
                rem_next = rem_new;
                quo_next = quo_new;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    sw_next    = {1'b0, quo_new};
                    state_next = ST_R_MUL1;
                end
            end

            ST_R_MUL1:
            begin
                p1_next    = 33'(ent.density) * 33'(sw_reg);
                state_next = ST_R_MUL2;
            end

            ST_R_MUL2:
            begin
                p2_next    = 50'(p1_reg) * 50'(Q16_ONE - t_reg);
                state_next = ST_R_OUT;
            end

            ST_R_OUT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {count_reg, ent.seed, t_reg,
                                   ext_sat(mv_reg, negv_reg), ext_sat(mh_reg, negh_reg),
                                   p2_reg[47:32], ent.pos_z, ent.pos_y, ent.pos_x};
                    muser_next  = 1'b1;
                    mlast_next  = rec_last;
                    if (rec_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        src_next   = src_reg + 1'b1;
                        state_next = ST_R_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            fade_reg   <= FADE_RESET;
            src_reg    <= '0;
            dst_reg    <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            fade_reg   <= fade_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tv_reg      <= tv_next;
        rm_reg      <= rm_next;
        age_reg     <= age_next;
        expired_reg <= expired_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        gmul_reg    <= gmul_next;
        absh_reg    <= absh_next;
        absv_reg    <= absv_next;
        negh_reg    <= negh_next;
        negv_reg    <= negv_next;
        mh_reg      <= mh_next;
        mv_reg      <= mv_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        quo_reg     <= quo_next;
        t_reg       <= t_next;
        sw_reg      <= sw_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        mdata_reg   <= mdata_next;
        muser_reg   <= muser_next;
        mlast_reg   <= mlast_next;
    end

endmodule

// ===== rtl/core/evp_checker.sv =====
// Port-level checker for the effect volume pool, bound to the top level.
// Depends on evp_pkg and effect_volume_pool_macros.svh.
`include "effect_volume_pool_macros.svh"

module evp_checker #(
    parameter int POOL_CAPACITY = evp_pkg::POOL_CAPACITY_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [evp_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           m_tlast
);

    import evp_pkg::*;

    // A stalled result beat keeps its contents.
    `EVP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // An empty record is always the only, and so the final, beat of its item.
    `EVP_ASSERT_NOW(a_empty_last, m_tvalid && !m_tuser[0], m_tlast, "empty record without tlast")

    // The live count never exceeds the pool capacity.
    `EVP_ASSERT_NOW(a_live_cap, m_tvalid, m_tdata[OUT_LIVE_LSB +: CNT_W] <= CNT_W'(POOL_CAPACITY), "live count above capacity")

    // A surviving entry has not reached the end of its life.
    `EVP_ASSERT_NOW(a_prog_below_one, m_tvalid && m_tuser[0], !m_tdata[OUT_PROG_LSB + 16], "live record with full progress")

endmodule

bind effect_volume_pool evp_checker #(
    .POOL_CAPACITY (POOL_CAPACITY)
) u_evp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_effect_volume_pool.sv =====
// Self-checking testbench for effect_volume_pool: emit, tick, clear and unused items,
// fade register sweeps, pool overflow and output back-pressure. Depends on evp_pkg.
module tb_effect_volume_pool;
    import evp_pkg::*;

    localparam int          POOL_SIZE   = 64;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 5000000;

    // One input beat with its fields split out.
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] px, py, pz, rise, tv;
        logic [15:0] dens;
        logic [31:0] growth;
        logic [30:0] radius, height;
        logic [15:0] scale, seed;
    } vol_item_t;

    // One result beat with its fields split out.
    typedef struct {
        logic        vr;
        logic [31:0] x, y, z;
        logic [15:0] dens;
        logic [31:0] eh, ev;
        logic [16:0] prog;
        logic [15:0] seed;
        logic [6:0]  live;
        logic        last;
    } vol_record_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic [1:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [0:0]              m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [FADE_W-1:0]       cfg_data = '0;

    // Shadow copy of the pool and the fade register.
    evp_entry_t         pool_shadow [POOL_SIZE];
    int unsigned        pool_live;
    logic [FADE_W-1:0]  fade_shadow;
    vol_record_t        pending_records [$];

    int  mismatches   = 0;
    int  beats_in     = 0;
    int  beats_out    = 0;
    int  peak_live    = 0;
    int  fade_writes  = 0;
    int  stall_left   = 0;
    bit  steady       = 1'b0;
    longint cycles    = 0;

    effect_volume_pool dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic vol_record_t blank_record(int unsigned live);
        vol_record_t r;
        r = '{default: '0};
        r.live = live[6:0];
        r.last = 1'b1;
        return r;
    endfunction

    // Extent: (base +/- (|growth|*age >> 16)) * scale >> 8, truncated toward zero, saturated to 32 bits.
    function automatic logic [31:0] grown_extent(evp_entry_t e, logic [30:0] base);
        longint signed   g, sum, res;
        longint unsigned gmag, gm, smag, m, agev, basev, sc;
        g     = $signed(e.growth);
        gmag  = (g < 0) ? -g : g;
        agev  = e.age;
        gm    = (gmag * agev) >> 16;
        basev = base;
        sum   = longint'(basev) + ((g < 0) ? -longint'(gm) : longint'(gm));
        smag  = (sum < 0) ? -sum : sum;
        sc    = e.scale;
        m     = (smag * sc) >> 8;
        if (m > 64'h1_0000_0000)
            m = 64'h1_0000_0000;
        res = (sum < 0) ? -longint'(m) : longint'(m);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic vol_record_t entry_record(int unsigned i, bit last);
        vol_record_t     r;
        evp_entry_t      e;
        longint unsigned lifev, agev, p, fade, sw, dd;
        e     = pool_shadow[i];
        lifev = (e.life == 0) ? 1 : e.life;
        agev  = e.age;
        p     = (agev << 16) / lifev;
        if (p > 65536)
            p = 65536;
        fade  = (fade_shadow == 0) ? 1 : fade_shadow;
        sw    = (p << 16) / fade;
        if (sw > 65536)
            sw = 65536;
        dd     = e.density;
        r.vr   = 1'b1;
        r.x    = e.pos_x;
        r.y    = e.pos_y;
        r.z    = e.pos_z;
        r.dens = 16'((dd * sw * (65536 - p)) >> 32);
        r.eh   = grown_extent(e, e.radius);
        r.ev   = grown_extent(e, e.height);
        r.prog = p[16:0];
        r.seed = e.seed;
        r.live = pool_live[6:0];
        r.last = last;
        return r;
    endfunction

    // Age every entry, swap-remove the expired ones, then report the survivors.
    function automatic void age_pool(logic [31:0] dt);
        int unsigned     i;
        longint signed   rs, z;
        longint unsigned rmag, m, d, dhi, dlo, sc, a;
        dhi = dt[31:16];
        dlo = dt[15:0];
        i   = 0;
        while (i < pool_live)
        begin
            rs   = $signed(pool_shadow[i].rise);
            rmag = (rs < 0) ? -rs : rs;
            sc   = pool_shadow[i].scale;
            m    = rmag * sc;
            d    = (m * dhi + ((m * dlo) >> 16)) >> 24;
            z    = longint'($signed(pool_shadow[i].pos_z))
                   + ((rs < 0) ? -longint'(d) : longint'(d));
            if (z > 64'sd2147483647)
                z = 64'sd2147483647;
            if (z < -64'sd2147483648)
                z = -64'sd2147483648;
            pool_shadow[i].pos_z = z[31:0];
            a = pool_shadow[i].age;
            a = a + dt;
            pool_shadow[i].age = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
            if (pool_shadow[i].age >= pool_shadow[i].life)
            begin
                pool_live--;
                pool_shadow[i] = pool_shadow[pool_live];
            end
            else
                i++;
        end
        if (pool_live == 0)
            pending_records.push_back(blank_record(0));
        else
            for (i = 0; i < pool_live; i++)
                pending_records.push_back(entry_record(i, i + 1 == pool_live));
    endfunction

    function automatic void predict_item(vol_item_t it);
        int unsigned k;
        case (it.kind)
            KIND_EMIT:
            begin
                if (pool_live >= POOL_SIZE)
                    pending_records.push_back(blank_record(pool_live));
                else
                begin
                    k = pool_live;
                    pool_live++;
                    pool_shadow[k].pos_x   = it.px;
                    pool_shadow[k].pos_y   = it.py;
                    pool_shadow[k].pos_z   = it.pz;
                    pool_shadow[k].rise    = it.rise;
                    pool_shadow[k].life    = (it.tv < MIN_LIFE) ? MIN_LIFE : it.tv;
                    pool_shadow[k].density = it.dens;
                    pool_shadow[k].growth  = it.growth;
                    pool_shadow[k].radius  = it.radius;
                    pool_shadow[k].height  = it.height;
                    pool_shadow[k].age     = '0;
                    pool_shadow[k].seed    = it.seed;
                    pool_shadow[k].scale   = it.scale;
                    pending_records.push_back(entry_record(k, 1'b1));
                    if (pool_live > peak_live)
                        peak_live = pool_live;
                end
            end
            KIND_TICK:
                age_pool(it.tv);
            KIND_CLEAR:
            begin
                pool_live = 0;
                pending_records.push_back(blank_record(0));
            end
            default:
                pending_records.push_back(blank_record(pool_live));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generation and checking
    // ------------------------------------------------------------------

    // The receiver stalls at random, except during steady stretches. A requested
    // hold-off keeps ready low until its counter has run down.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 35);
    end

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        vol_record_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (pending_records.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected, got tdata 0x%0h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("valid_res",         want.vr,   m_tuser[0]);
                check_field("out_x",             want.x,    m_tdata[31:0]);
                check_field("out_y",             want.y,    m_tdata[63:32]);
                check_field("out_z",             want.z,    m_tdata[95:64]);
                check_field("density_now",       want.dens, m_tdata[111:96]);
                check_field("extent_horizontal", want.eh,   m_tdata[143:112]);
                check_field("extent_vertical",   want.ev,   m_tdata[175:144]);
                check_field("progress",          want.prog, m_tdata[192:176]);
                check_field("seed_out",          want.seed, m_tdata[208:193]);
                check_field("live_count",        want.live, m_tdata[215:209]);
                check_field("last",              want.last, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drives one beat and waits for it to be taken. Valid stays high on return so that
    // back-to-back beats need no second assignment in the same step.
    task automatic send_item(input vol_item_t it);
        while (!steady && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b00, it.seed, it.scale, it.height, it.radius, it.growth,
                     it.dens, it.tv, it.rise, it.pz, it.py, it.px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_in++;
        predict_item(it);
    endtask

    // Lowers valid after the last beat of a phase and waits for every record to arrive.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_fade(input logic [FADE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        fade_shadow  = value;
        fade_writes++;
        @(posedge clk);
    endtask

    // Mostly well-formed content: lives and tick steps sized so that entries survive a
    // few ticks, with some full-range values mixed in so every bit toggles.
    function automatic vol_item_t random_item();
        vol_item_t it;
        int unsigned pick;
        it.px     = $urandom;
        it.py     = $urandom;
        it.pz     = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0040_0000);
        it.rise   = ($urandom_range(3) == 0) ? $urandom
                                              : $signed($urandom_range(32'h0008_0000)) - 32'sh4_0000;
        it.dens   = 16'($urandom);
        it.growth = ($urandom_range(3) == 0) ? $urandom
                                              : $signed($urandom_range(32'h0004_0000)) - 32'sh2_0000;
        it.radius = 31'($urandom);
        it.height = 31'($urandom);
        it.scale  = 16'($urandom);
        it.seed   = 16'($urandom);
        pick      = $urandom_range(99);
        if (pick < 45)
        begin
            it.kind = KIND_EMIT;
            case ($urandom_range(3))
                0:       it.tv = $urandom_range(65536);
                1, 2:    it.tv = $urandom_range(32'h0010_0000, 32'h0001_0000);
                default: it.tv = $urandom;
            endcase
        end
        else if (pick < 88)
        begin
            it.kind = KIND_TICK;
            it.tv   = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0002_0000);
        end
        else if (pick < 95)
        begin
            it.kind = KIND_CLEAR;
            it.tv   = $urandom;
        end
        else
        begin
            it.kind = KIND_UNUSED;
            it.tv   = $urandom;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, life floor, every item kind, the empty tick and refusal cases.
    task automatic test_directed();
        vol_item_t it;
        it = random_item();
        it.kind = KIND_TICK;   it.tv = 32'h0001_0000;   send_item(it);  // tick on empty pool
        it.kind = KIND_EMIT;
        it.px = 32'h7FFF_FFFF; it.py = 32'h8000_0000; it.pz = 32'h7FFF_FF00;
        it.rise = 32'h7FFF_FFFF; it.tv = 32'hFFFF_FFFF; it.dens = 16'hFFFF;
        it.growth = 32'h7FFF_FFFF; it.radius = 31'h7FFF_FFFF; it.height = 31'h7FFF_FFFF;
        it.scale = 16'hFFFF; it.seed = 16'hFFFF;
        send_item(it);
        it.px = 32'h8000_0000; it.py = 32'h7FFF_FFFF; it.pz = 32'h8000_0100;
        it.rise = 32'h8000_0000; it.growth = 32'h8000_0000; it.radius = '0; it.height = '0;
        it.dens = '0; it.scale = '0; it.seed = '0;
        send_item(it);
        // Zero life is raised to the one-millisecond floor.
        it = random_item(); it.kind = KIND_EMIT; it.tv = '0; send_item(it);
        it = random_item(); it.kind = KIND_EMIT; it.tv = 32'd65; send_item(it);
        it = random_item(); it.kind = KIND_EMIT; it.tv = 32'h0000_4000;
        it.growth = 32'h8000_0000; it.scale = 16'hFFFF; send_item(it);
        it = random_item(); it.kind = KIND_TICK; it.tv = '0; send_item(it);
        it.tv = 32'd40; send_item(it);   // short lives just short of expiry
        it.tv = 32'h0000_2000; send_item(it);
        it.tv = 32'hFFFF_FFFF; send_item(it);   // age saturates, every entry expires
        it = random_item(); it.kind = KIND_UNUSED; send_item(it);
        it = random_item(); it.kind = KIND_EMIT; send_item(it);
        it = random_item(); it.kind = KIND_UNUSED; send_item(it);
        it = random_item(); it.kind = KIND_CLEAR; send_item(it);
        it = random_item(); it.kind = KIND_TICK; send_item(it);
        wait_idle();
    endtask

    // Fills the pool past capacity, ages it, and clears it.
    task automatic test_pool_overflow();
        vol_item_t it;
        steady = 1'b1;
        for (int n = 0; n < POOL_SIZE + 2; n++)
        begin
            it = random_item();
            it.kind = KIND_EMIT;
            it.tv = $urandom_range(32'h0008_0000, 32'h0000_0100);
            send_item(it);
        end
        steady = 1'b0;
        it = random_item(); it.kind = KIND_UNUSED; send_item(it);
        it = random_item(); it.kind = KIND_TICK; it.tv = 32'h0000_8000; send_item(it);
        it.tv = 32'h0001_0000; send_item(it);
        it = random_item(); it.kind = KIND_CLEAR; send_item(it);
        wait_idle();
    endtask

    // The receiver holds off while the sender keeps offering beats, so the block
    // backs up and stalls its input.
    task automatic test_backpressure();
        vol_item_t it;
        for (int n = 0; n < 6; n++)
        begin
            it = random_item();
            it.kind = KIND_EMIT;
            it.tv = 32'h0010_0000;
            send_item(it);
        end
        stall_left = 400;
        for (int n = 0; n < 10; n++)
        begin
            it = random_item();
            if (n % 3 == 0)
            begin
                it.kind = KIND_TICK;
                it.tv = $urandom_range(32'h0000_4000);
            end
            send_item(it);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [FADE_W-1:0] fade, input int count);
        write_fade(fade);
        for (int n = 0; n < count; n++)
        begin
            // A steady stretch of up to ten items, starting a third of the way into each phase.
            steady = (n >= count / 3) && (n < count / 3 + 10);
            send_item(random_item());
        end
        steady = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        fade_shadow = FADE_RESET;
        pool_live   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pool_overflow();
        test_random_traffic(17'd1, 15);
        test_random_traffic(Q16_ONE, 15);
        test_random_traffic(17'($urandom_range(65536, 1)), 15);
        test_random_traffic(FADE_RESET, 15);
        test_backpressure();

        repeat (100) @(posedge clk);
        $display("Covered %0d input beats and %0d result beats, %0d fade writes,",
                 beats_in, beats_out, fade_writes);
        $display("with the pool peaking at %0d live entries.", peak_live);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
